>>> hw/rtl/tdplv_pkg.sv
`default_nettype none
package tdplv_pkg;

	localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;
	localparam logic signed [63:0] KELVIN_OFS_Q48 = 64'sd76884889888515686;

	typedef enum logic [2:0] {
		REG_CONSIST_C0,
		REG_CONSIST_C1,
		REG_CONSIST_C2,
		REG_INDEX_C0,
		REG_INDEX_C1,
		REG_INDEX_C2,
		REG_VISC_FLOOR,
		REG_VISC_CEILING
	} reg_idx_t;

	typedef struct packed {
		logic [30:0]        temperature;
		logic signed [31:0] grad_xx;
		logic signed [31:0] grad_xy;
		logic signed [31:0] grad_xz;
		logic signed [31:0] grad_yx;
		logic signed [31:0] grad_yy;
		logic signed [31:0] grad_yz;
		logic signed [31:0] grad_zx;
		logic signed [31:0] grad_zy;
		logic signed [31:0] grad_zz;
	} in_t;

	typedef struct packed {
		logic [62:0] viscosity;
		logic        was_clamped;
	} out_t;

	// elaboration-time table builders
	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bit_v;
		n = n_in;
		res = '0;
		bit_v = 64'h4000_0000_0000_0000;
		for (int j = 0; j < 32; j++) begin
			if (n >= res + bit_v) begin
				n = n - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] log_entry(input int i, input int b);
		logic [63:0] m;
		logic [31:0] r;
		m = 64'h8000_0000 + (64'(i) << (31 - b));
		r = '0;
		for (int j = 31; j >= 0; j--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				r[j] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] exp_entry(input int i, input int b);
		logic [63:0] root;
		logic [63:0] a;
		a = 64'h8000_0000;
		root = 64'h1_0000_0000;
		for (int k = 1; k <= b; k++) begin
			root = isqrt64(root << 31);
			if (((i >> (b - k)) & 1) != 0) begin
				a = (a * root) >> 31;
			end
		end
		return a[31:0];
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/temp_dependent_power_law_viscosity.sv
`default_nettype none
// Power-law viscosity with temperature-dependent consistency and flow index.
// One item (cell) is taken every cycle; busy never rises. The result strobe
// done pulses for one cycle when the item's result is registered, and the
// receiver cannot stall it. The depth is set by the strain path (squares, sums,
// leading one, log2 table read) and then the 64x64 multiply of exponent times
// log strain, built like the Horner steps from 32x32 partial products over two
// stages, plus the exp2 table read. Registers are to be written by the user
// through cfg_we/cfg_index/cfg_data only while no item is in flight; the block does not enforce it.
module temp_dependent_power_law_viscosity #(
	parameter int LOG_TABLE_BITS = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire tdplv_pkg::in_t   item,
	output logic                  done,
	output tdplv_pkg::out_t       result,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [63:0]      cfg_data
);
	import tdplv_pkg::*;

	localparam int B = LOG_TABLE_BITS;
	localparam int NSTG = 14;

	// configuration
	logic signed [63:0] consist_c0_q, consist_c1_q, consist_c2_q;
	logic signed [63:0] index_c0m1_q, index_c1_q, index_c2_q;
	logic [62:0]        visc_floor_q, visc_ceiling_q;
	logic signed [64:0] n0m1;

	always_comb begin
		n0m1 = $signed({cfg_data[63], cfg_data}) - $signed({1'b0, ONE_Q48});
		if (n0m1 < -$signed({1'b0, SMAX})) n0m1 = -$signed({1'b0, SMAX});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consist_c0_q <= '0;
			consist_c1_q <= '0;
			consist_c2_q <= '0;
			index_c0m1_q <= '0;
			index_c1_q <= '0;
			index_c2_q <= '0;
			visc_floor_q <= '0;
			visc_ceiling_q <= SMAX[62:0];
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONSIST_C0: consist_c0_q <= cfg_data;
				REG_CONSIST_C1: consist_c1_q <= cfg_data;
				REG_CONSIST_C2: consist_c2_q <= cfg_data;
				REG_INDEX_C0: index_c0m1_q <= n0m1[63:0];
				REG_INDEX_C1: index_c1_q <= cfg_data;
				REG_INDEX_C2: index_c2_q <= cfg_data;
				REG_VISC_FLOOR: visc_floor_q <= cfg_data[62:0];
				REG_VISC_CEILING: visc_ceiling_q <= cfg_data[62:0];
				default: ;
			endcase
		end
	end

	// valid chain
	logic [NSTG:1] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[NSTG-1:1], start};
	end

	assign busy = 1'b0;
	assign done = vld_q[NSTG];

	// stage 1: capture
	logic signed [31:0] g_s1 [9];
	logic signed [63:0] tq_s1, dt_s1, tq_s2, tq_s3, dt_s2, dt_s3;
	logic signed [63:0] tq_in;

	assign tq_in = $signed({1'b0, item.temperature, 32'd0});

	always_ff @(posedge clk) begin
		g_s1[0] <= item.grad_xx;
		g_s1[1] <= item.grad_xy;
		g_s1[2] <= item.grad_xz;
		g_s1[3] <= item.grad_yx;
		g_s1[4] <= item.grad_yy;
		g_s1[5] <= item.grad_yz;
		g_s1[6] <= item.grad_zx;
		g_s1[7] <= item.grad_zy;
		g_s1[8] <= item.grad_zz;
		tq_s1 <= tq_in;
		dt_s1 <= tq_in - KELVIN_OFS_Q48;
		tq_s2 <= tq_s1;
		tq_s3 <= tq_s2;
		dt_s2 <= dt_s1;
		dt_s3 <= dt_s2;
	end

	// consistency and exponent polynomials
	logic signed [63:0] hk_s3, kc_s5, he_s3, e_s5;

	tdplv_smul u_k1 (.clk(clk), .a(consist_c2_q), .b(dt_s1), .addend(consist_c1_q), .y(hk_s3));
	tdplv_smul u_k2 (.clk(clk), .a(hk_s3), .b(dt_s3), .addend(consist_c0_q), .y(kc_s5));
	tdplv_smul u_e1 (.clk(clk), .a(index_c2_q), .b(tq_s1), .addend(index_c1_q), .y(he_s3));
	tdplv_smul u_e2 (.clk(clk), .a(he_s3), .b(tq_s3), .addend(index_c0m1_q), .y(e_s5));

	// strain: squares
	logic [31:0] md [3];
	logic [32:0] mc [3];
	logic [32:0] cs [3];
	logic [63:0] sqd_s2 [3];
	logic [65:0] sqc_s2 [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			md[k] = g_s1[4*k][31] ? (32'd0 - g_s1[4*k]) : g_s1[4*k];
		end
		cs[0] = {g_s1[1][31], g_s1[1]} + {g_s1[3][31], g_s1[3]};
		cs[1] = {g_s1[2][31], g_s1[2]} + {g_s1[6][31], g_s1[6]};
		cs[2] = {g_s1[5][31], g_s1[5]} + {g_s1[7][31], g_s1[7]};
		for (int k = 0; k < 3; k++) begin
			mc[k] = cs[k][32] ? (33'd0 - cs[k]) : cs[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sqd_s2[k] <= 64'(md[k]) * 64'(md[k]);
			sqc_s2[k] <= 66'(mc[k]) * 66'(mc[k]);
		end
	end

	logic [64:0] sa_s3;
	logic [65:0] sb_s3;
	logic [66:0] q_s4, qsum;

	// each diagonal square is at most 2^62, so the sum fits 64 bits
	always_ff @(posedge clk) begin
		sa_s3 <= {sqd_s2[0] + sqd_s2[1] + sqd_s2[2], 1'b0};
		sb_s3 <= sqc_s2[0] + sqc_s2[1] + sqc_s2[2];
	end

	assign qsum = {2'b00, sa_s3} + {1'b0, sb_s3};

	always_ff @(posedge clk) begin
		q_s4 <= (qsum == '0) ? 67'd1 : qsum;
	end

	// leading one and log table
	logic [6:0]   p_lead, p_s5, p_s6;
	logic [66:0]  q_s5;
	logic [127:0] qx;
	logic [31:0]  lt_s6;

	always_comb begin
		p_lead = '0;
		for (int k = 0; k < 67; k++) begin
			if (q_s4[k]) p_lead = 7'(k);
		end
	end

	always_ff @(posedge clk) begin
		p_s5 <= p_lead;
		q_s5 <= q_s4;
		p_s6 <= p_s5;
	end

	assign qx = {61'd0, q_s5} << (7'd127 - p_s5);

	tdplv_rom #(.LOG_TABLE_BITS(B), .IS_EXP(1'b0)) u_log (
		.clk(clk), .addr(qx[126 -: B]), .data(lt_s6)
	);

	logic [38:0]        lq;
	logic signed [39:0] ls_s7;
	logic signed [63:0] e_s6, e_s7, z_s9;

	assign lq = {p_s6, lt_s6};

	always_ff @(posedge clk) begin
		ls_s7 <= $signed({2'b00, lq[38:1]}) - 40'sh10_0000_0000;
		e_s6 <= e_s5;
		e_s7 <= e_s6;
	end

	tdplv_smul u_z (
		.clk(clk), .a(e_s7), .b({{24{ls_s7[39]}}, ls_s7}), .addend(64'sd0), .y(z_s9)
	);

	// power and scale
	logic signed [63:0] kc_s6, kc_s7, kc_s8, kc_s9, kc_s10;
	logic signed [31:0] zi_s10, zi_s11, zi_s12;
	logic [31:0]        et_s10;

	always_ff @(posedge clk) begin
		kc_s6 <= kc_s5;
		kc_s7 <= kc_s6;
		kc_s8 <= kc_s7;
		kc_s9 <= kc_s8;
		kc_s10 <= kc_s9;
		zi_s10 <= z_s9[63:32];
	end

	tdplv_rom #(.LOG_TABLE_BITS(B), .IS_EXP(1'b1)) u_exp (
		.clk(clk), .addr(z_s9[31 -: B]), .data(et_s10)
	);

	logic [63:0] mkc;
	logic [63:0] pl_s11, ph_s11;
	logic        neg_s11, neg_s12, neg_s13;
	logic [95:0] m_s12;

	assign mkc = kc_s10[63] ? (64'd0 - kc_s10) : kc_s10;

	always_ff @(posedge clk) begin
		pl_s11 <= 64'(mkc[31:0]) * 64'(et_s10);
		ph_s11 <= 64'(mkc[63:32]) * 64'(et_s10);
		neg_s11 <= kc_s10[63];
		zi_s11 <= zi_s10;
		m_s12 <= {ph_s11, 32'd0} + {32'd0, pl_s11};
		neg_s12 <= neg_s11;
		zi_s12 <= zi_s11;
	end

	logic signed [33:0] sr, sl;
	logic [95:0]        tr;
	logic [159:0]       tl;
	logic [63:0]        mk, mk_s13;

	always_comb begin
		sr = 34'sd31 - $signed({{2{zi_s12[31]}}, zi_s12});
		sl = -sr;
		tr = m_s12 >> sr[6:0];
		tl = {64'd0, m_s12} << sl[5:0];
		if (zi_s12 <= 32'sd31) begin
			if (sr >= 34'sd96) mk = '0;
			else mk = (tr > {32'd0, SMAX}) ? SMAX : tr[63:0];
		end else if (m_s12 == '0) begin
			mk = '0;
		end else if (sl >= 34'sd64) begin
			mk = SMAX;
		end else begin
			mk = (tl > {96'd0, SMAX}) ? SMAX : tl[63:0];
		end
	end

	always_ff @(posedge clk) begin
		mk_s13 <= mk;
		neg_s13 <= neg_s12;
	end

	// clamp
	logic signed [63:0] x, y, fl, cl;

	always_comb begin
		x = neg_s13 ? -$signed(mk_s13) : $signed(mk_s13);
		fl = $signed({1'b0, visc_floor_q});
		cl = $signed({1'b0, visc_ceiling_q});
		y = (x > cl) ? cl : x;
		y = (y < fl) ? fl : y;
	end

	always_ff @(posedge clk) begin
		result.viscosity <= y[62:0];
		result.was_clamped <= (y != x);
	end

endmodule
`default_nettype wire

>>> hw/rtl/tdplv_smul.sv
`default_nettype none
// y = sat(addend + sat((a*b) >> 48)), two stages
module tdplv_smul (
	input  wire logic               clk,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	input  wire logic signed [63:0] addend,
	output logic signed [63:0]      y
);
	import tdplv_pkg::*;

	logic [63:0] ma, mb;
	logic [63:0] pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic        neg_s1;

	always_comb begin
		ma = a[63] ? (64'd0 - a) : a;
		mb = b[63] ? (64'd0 - b) : b;
	end

	always_ff @(posedge clk) begin
		pp00_s1 <= 64'(ma[31:0]) * 64'(mb[31:0]);
		pp01_s1 <= 64'(ma[31:0]) * 64'(mb[63:32]);
		pp10_s1 <= 64'(ma[63:32]) * 64'(mb[31:0]);
		pp11_s1 <= 64'(ma[63:32]) * 64'(mb[63:32]);
		neg_s1 <= a[63] ^ b[63];
	end

	logic [127:0]       prod;
	logic [79:0]        sh;
	logic [63:0]        mg;
	logic signed [65:0] v, sum, lim;

	always_comb begin
		prod = {pp11_s1, 64'd0} + {32'd0, pp01_s1, 32'd0} + {32'd0, pp10_s1, 32'd0}
			+ {64'd0, pp00_s1};
		sh = prod[127:48];
		mg = (sh > {16'd0, SMAX}) ? SMAX : sh[63:0];
		v = neg_s1 ? -$signed({2'b00, mg}) : $signed({2'b00, mg});
		lim = $signed({2'b00, SMAX});
		sum = $signed({{2{addend[63]}}, addend}) + v;
		if (sum > lim) sum = lim;
		else if (sum < -lim && v < 0) sum = -lim;
	end

	always_ff @(posedge clk) begin
		y <= sum[63:0];
	end

endmodule
`default_nettype wire

>>> hw/rtl/tdplv_rom.sv
`default_nettype none
module tdplv_rom #(
	parameter int LOG_TABLE_BITS = 10,
	parameter bit IS_EXP = 1'b0
) (
	input  wire logic                      clk,
	input  wire logic [LOG_TABLE_BITS-1:0] addr,
	output logic [31:0]                    data
);
	import tdplv_pkg::*;

	localparam int TBL = 1 << LOG_TABLE_BITS;

	logic [31:0] rom [TBL];

	for (genvar i = 0; i < TBL; i++) begin : g_ent
		localparam logic [31:0] ENT = IS_EXP ? exp_entry(i, LOG_TABLE_BITS)
			: log_entry(i, LOG_TABLE_BITS);
		assign rom[i] = ENT;
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tdplv_pkg::*;

	localparam int TB = 10;
	localparam int TSZ = 1 << TB;
	localparam int LAT = 14;

	typedef struct {
		int   setting;
		in_t  stim;
		bit   typed;
		logic [62:0] visc;
		bit   clamped;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t  item;
	logic done;
	out_t result;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	logic [31:0] log2_rom [TSZ];
	logic [31:0] exp2_rom [TSZ];
	logic signed [63:0] k0, k1, k2, n0, n1, n2, vfloor, vceil;
	out_t visc_q [$];
	int   mism;
	int   sent;
	int   idle_pct;
	logic [63:0] cfg_sets [4][8];
	row_t rows [$];

	temp_dependent_power_law_viscosity #(.LOG_TABLE_BITS(TB)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("** temp_dependent_power_law_viscosity: FAILED **");
		$finish;
	end

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= {64'd0, n}) r = t;
		end
		return r;
	endfunction

	task automatic build_roms();
		logic [63:0] roots [TB + 1];
		logic [63:0] m;
		logic [63:0] a;
		logic [31:0] r;
		roots[0] = 64'd1 << 32;
		for (int k = 1; k <= TB; k++) roots[k] = floor_sqrt(roots[k - 1] << 31);
		for (int i = 0; i < TSZ; i++) begin
			m = (64'd1 << 31) + (64'(i) << (31 - TB));
			r = '0;
			for (int b = 31; b >= 0; b--) begin
				m = (m * m) >> 31;
				if (m >= (64'd1 << 32)) begin
					m = m >> 1;
					r[b] = 1'b1;
				end
			end
			log2_rom[i] = r;
			a = 64'd1 << 31;
			for (int k = 1; k <= TB; k++)
				if ((i >> (TB - k)) & 1) a = (a * roots[k]) >> 31;
			exp2_rom[i] = a[31:0];
		end
	endtask

	function automatic logic [63:0] absv(input logic signed [63:0] a);
		return a[63] ? -a : a;
	endfunction

	function automatic logic signed [63:0] signed_of(input logic [63:0] m, input bit neg);
		logic [63:0] c;
		c = (m > SMAX) ? SMAX : m;
		return neg ? -$signed(c) : $signed(c);
	endfunction

	function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
			input logic signed [63:0] b, input int s);
		logic [127:0] p;
		p = ({64'd0, absv(a)} * {64'd0, absv(b)}) >> s;
		return signed_of((p > {64'd0, SMAX}) ? SMAX : p[63:0], a[63] != b[63]);
	endfunction

	function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > $signed({1'b0, SMAX})) return $signed(SMAX);
		if (s < -$signed({1'b0, SMAX})) return -$signed(SMAX);
		return s[63:0];
	endfunction

	function automatic out_t viscosity_of(input in_t c);
		logic signed [31:0] g [9];
		logic signed [32:0] pr;
		logic [127:0] q, sh, mp;
		logic [32:0] pm;
		int p;
		int idx;
		logic signed [63:0] lq, ls, tq, dt, h, kc, e, z, zi, x, y, s;
		logic [63:0] mk;
		out_t o;
		g = '{c.grad_xx, c.grad_xy, c.grad_xz, c.grad_yx, c.grad_yy, c.grad_yz,
			c.grad_zx, c.grad_zy, c.grad_zz};
		q = '0;
		for (int i = 0; i < 9; i += 4) q += 2 * (128'(absv(64'(g[i]))) * 128'(absv(64'(g[i]))));
		pr = 33'(g[1]) + 33'(g[3]); pm = pr[32] ? -pr : pr; q += 128'(pm) * 128'(pm);
		pr = 33'(g[2]) + 33'(g[6]); pm = pr[32] ? -pr : pr; q += 128'(pm) * 128'(pm);
		pr = 33'(g[5]) + 33'(g[7]); pm = pr[32] ? -pr : pr; q += 128'(pm) * 128'(pm);
		if (q == 0) q = 1;
		p = 0;
		for (int i = 0; i < 128; i++) if (q[i]) p = i;
		sh = q << (127 - p);
		idx = int'(sh[126 -: TB]);
		lq = (64'(p) << 32) + 64'(log2_rom[idx]);
		ls = (lq >>> 1) - (64'sd16 <<< 32);
		tq = $signed({1'b0, c.temperature, 32'd0});
		dt = tq - KELVIN_OFS_Q48;
		h = qadd(k1, qmul(k2, dt, 48));
		kc = qadd(k0, qmul(h, dt, 48));
		h = qadd(n1, qmul(n2, tq, 48));
		e = qadd(qadd(n0, -$signed(ONE_Q48)), qmul(h, tq, 48));
		z = qmul(e, ls, 48);
		zi = z >>> 32;
		idx = int'(z[31 -: TB]);
		mp = 128'(absv(kc)) * 128'(exp2_rom[idx]);
		if (zi <= 31) begin
			s = 31 - zi;
			sh = (s >= 128) ? 128'd0 : (mp >> s);
			mk = (sh > {64'd0, SMAX}) ? SMAX : sh[63:0];
		end else if (mp == 0) begin
			mk = 0;
		end else begin
			s = zi - 31;
			if (s >= 64 || mp[127:64] != 0 || (mp[63:0] >> (63 - s)) != 0) mk = SMAX;
			else mk = mp[63:0] << s;
		end
		x = signed_of(mk, kc[63]);
		y = (x > vceil) ? vceil : x;
		y = (y < vfloor) ? vfloor : y;
		o.viscosity = y[62:0];
		o.was_clamped = (y != x);
		return o;
	endfunction

	// monitor: result compare against oldest expectation
	always @(posedge clk) begin
		out_t exp_o;
		if (arst_n && done) begin
			if (visc_q.size() == 0) begin
				mism++;
				if (mism <= 10) $display("unexpected result %h", result);
			end else begin
				exp_o = visc_q.pop_front();
				if (result.viscosity !== exp_o.viscosity ||
						result.was_clamped !== exp_o.was_clamped) begin
					mism++;
					if (mism <= 10)
						$display("mismatch: exp visc %h clamp %b, got visc %h clamp %b",
							exp_o.viscosity, exp_o.was_clamped,
							result.viscosity, result.was_clamped);
				end
			end
		end
	end

	task automatic send_cell(input in_t c, input bit typed, input out_t tv);
		bit b;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= c;
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
		visc_q.push_back(typed ? tv : viscosity_of(c));
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (visc_q.size() != 0) @(posedge clk);
		repeat (LAT + 6) @(posedge clk);
	endtask

	task automatic load_regs(input logic [63:0] v [8]);
		reg_idx_t r;
		for (int i = 0; i < 8; i++) begin
			r = reg_idx_t'(i);
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_data <= v[i];
			case (r)
				REG_CONSIST_C0: k0 = v[i];
				REG_CONSIST_C1: k1 = v[i];
				REG_CONSIST_C2: k2 = v[i];
				REG_INDEX_C0: n0 = v[i];
				REG_INDEX_C1: n1 = v[i];
				REG_INDEX_C2: n2 = v[i];
				REG_VISC_FLOOR: vfloor = {1'b0, v[i][62:0]};
				REG_VISC_CEILING: vceil = {1'b0, v[i][62:0]};
				default: ;
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [63:0] rnd_small(input int bits);
		logic signed [63:0] v;
		v = $signed(rnd64()) >>> (64 - bits);
		return v;
	endfunction

	function automatic in_t rand_cell();
		in_t c;
		int kind;
		kind = $urandom_range(9);
		c = 319'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom});
		if (kind < 7) begin
			c.temperature = (31'($urandom_range(220, 480)) << 16) | 31'($urandom_range(65535));
			c.grad_xx = 32'(rnd_small($urandom_range(4, 26)));
			c.grad_xy = 32'(rnd_small($urandom_range(4, 26)));
			c.grad_xz = 32'(rnd_small($urandom_range(4, 26)));
			c.grad_yx = 32'(rnd_small($urandom_range(4, 26)));
			c.grad_yy = 32'(rnd_small($urandom_range(4, 26)));
			c.grad_yz = 32'(rnd_small($urandom_range(4, 26)));
			c.grad_zx = 32'(rnd_small($urandom_range(4, 26)));
			c.grad_zy = 32'(rnd_small($urandom_range(4, 26)));
			c.grad_zz = 32'(rnd_small($urandom_range(4, 26)));
		end else if (kind == 7) begin
			c.grad_xx = 0; c.grad_xy = 0; c.grad_xz = 0; c.grad_yx = 0; c.grad_yy = 0;
			c.grad_yz = 0; c.grad_zx = 0; c.grad_zy = 0; c.grad_zz = 0;
		end
		return c;
	endfunction

	task automatic rand_regs(input int mode, output logic [63:0] v [8]);
		if (mode == 0) begin
			v[0] = 64'($urandom_range(1, 1 << 20)) << 32;
			v[1] = rnd_small(41);
			v[2] = rnd_small(33);
			v[3] = 64'($urandom_range(13107, 117964)) << 32;
			v[4] = rnd_small(38);
			v[5] = rnd_small(29);
			v[6] = 64'($urandom_range(0, 1 << 16)) << 16;
			v[7] = 64'($urandom_range(1 << 16, 32'h7FFF_FFFF)) << 32;
		end else begin
			for (int i = 0; i < 8; i++) v[i] = rnd64();
		end
	endtask

	function automatic in_t cell_of(input logic [30:0] t, input logic [31:0] gv);
		in_t c;
		c.temperature = t;
		c.grad_xx = gv; c.grad_xy = gv; c.grad_xz = gv; c.grad_yx = gv; c.grad_yy = gv;
		c.grad_yz = gv; c.grad_zx = gv; c.grad_zy = gv; c.grad_zz = gv;
		return c;
	endfunction

	initial begin
		logic [63:0] regs [8];
		out_t tv;
		int cur;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mism = 0;
		sent = 0;
		idle_pct = 8;
		k0 = 0; k1 = 0; k2 = 0; n0 = ONE_Q48; n1 = 0; n2 = 0; vfloor = 0; vceil = SMAX;
		build_roms();
		cfg_sets[0] = '{64'd0, 64'd0, 64'd0, ONE_Q48, 64'd0, 64'd0, 64'd0, SMAX};
		cfg_sets[1] = '{-ONE_Q48, 64'd0, 64'd0, ONE_Q48, 64'd0, 64'd0, 5 * ONE_Q48,
			2 * ONE_Q48};
		cfg_sets[2] = '{SMAX, 64'd0, 64'd0, 8 * ONE_Q48, 64'd0, 64'd0, 64'd0, SMAX};
		cfg_sets[3] = '{64'h8000_0000_0000_0000, SMAX, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0000, SMAX, SMAX, 64'd1, SMAX};
		// zero consistency: everything is zero and unclamped
		rows.push_back('{0, cell_of(31'd0, 32'd0), 1, 63'd0, 0});
		rows.push_back('{0, cell_of(31'h7FFF_FFFF, 32'h7FFF_FFFF), 1, 63'd0, 0});
		rows.push_back('{0, cell_of(31'h7FFF_FFFF, 32'h8000_0000), 1, 63'd0, 0});
		rows.push_back('{0, cell_of(31'd0, 32'hFFFF_FFFF), 1, 63'd0, 0});
		// negative consistency with floor above ceiling: output is the floor
		rows.push_back('{1, cell_of(31'd300 << 16, 32'd65536), 1, 63'(5 * ONE_Q48), 1});
		rows.push_back('{1, cell_of(31'd0, 32'd0), 1, 63'(5 * ONE_Q48), 1});
		rows.push_back('{2, cell_of(31'd300 << 16, 32'd0), 0, 63'd0, 0});
		rows.push_back('{2, cell_of(31'd300 << 16, 32'h7FFF_FFFF), 0, 63'd0, 0});
		rows.push_back('{2, cell_of(31'd350 << 16, 32'h0001_0000), 0, 63'd0, 0});
		rows.push_back('{3, cell_of(31'h7FFF_FFFF, 32'h8000_0000), 0, 63'd0, 0});
		rows.push_back('{3, cell_of(31'd0, 32'h0000_0001), 0, 63'd0, 0});
		rows.push_back('{3, cell_of(31'd273 << 16, 32'h1234_5678), 0, 63'd0, 0});

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = -1;
		foreach (rows[i]) begin
			if (rows[i].setting != cur) begin
				drain();
				cur = rows[i].setting;
				load_regs(cfg_sets[cur]);
			end
			tv.viscosity = rows[i].visc;
			tv.was_clamped = rows[i].clamped;
			send_cell(rows[i].stim, rows[i].typed, tv);
		end

		for (int ph = 0; ph < 7; ph++) begin
			drain();
			if (ph == 6) regs = cfg_sets[0];
			else if (ph == 5) regs = cfg_sets[3];
			else rand_regs(ph == 4, regs);
			load_regs(regs);
			for (int n = 0; n < 100; n++) begin
				idle_pct = (sent < 245) ? 8 : (sent < 480) ? 82 : 0;
				send_cell(rand_cell(), 0, tv);
			end
		end

		drain();
		if (mism == 0) begin
			$display("** temp_dependent_power_law_viscosity: PASSED **");
		end else begin
			$display("** temp_dependent_power_law_viscosity: FAILED **");
		end
		$finish;
	end
endmodule
`default_nettype wire
